/* rtl/sit_pkg.sv */
// Shared types and constants for the segment intersection test.
package sit_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int TOL_WIDTH       = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;

    // Relation between the two segments
    typedef enum logic [2:0] {
        REL_CROSS    = 3'd0,
        REL_MISS     = 3'd1,
        REL_PARALLEL = 3'd2,
        REL_OVERLAP  = 3'd3,
        REL_DISJOINT = 3'd4
    } t_rel;

    typedef struct packed {
        logic intersects;
        t_rel relation;
    } t_result;

endpackage

/* rtl/sit_pipe.sv */
// Five-stage arithmetic pipeline: differences, products, sums, zero tests, decision.
module sit_pipe import sit_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_p_x,
    input  logic signed [COORD_WIDTH-1:0] i_p_y,
    input  logic signed [COORD_WIDTH-1:0] i_r_x,
    input  logic signed [COORD_WIDTH-1:0] i_r_y,
    input  logic signed [COORD_WIDTH-1:0] i_q_x,
    input  logic signed [COORD_WIDTH-1:0] i_q_y,
    input  logic signed [COORD_WIDTH-1:0] i_s_x,
    input  logic signed [COORD_WIDTH-1:0] i_s_y,
    input  logic [TOL_WIDTH-1:0]          i_tol,
    output logic                          o_valid,
    output t_result                       o_result
);

    localparam int DW = COORD_WIDTH + 1;   // operand width after subtraction
    localparam int PW = 2 * DW;            // exact product width
    localparam int AW = 2 * COORD_WIDTH + 4; // sum width, holds d0 + s.r

    // Stage 1: widen operands, form q - p
    logic                 r_v1;
    logic signed [DW-1:0] r_dx, r_dy, r_rx, r_ry, r_sx, r_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_dx <= DW'(i_q_x) - DW'(i_p_x);
            r_dy <= DW'(i_q_y) - DW'(i_p_y);
            r_rx <= DW'(i_r_x);
            r_ry <= DW'(i_r_y);
            r_sx <= DW'(i_s_x);
            r_sy <= DW'(i_s_y);
        end
    end

    // Stage 2: all exact products
    logic                 r_v2;
    logic signed [PW-1:0] r_rxsy, r_rysx, r_dxry, r_dyrx, r_dxsy, r_dysx;
    logic signed [PW-1:0] r_rxrx, r_ryry, r_dxrx, r_dyry, r_sxrx, r_syry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_rxsy <= r_rx * r_sy;
            r_rysx <= r_ry * r_sx;
            r_dxry <= r_dx * r_ry;
            r_dyrx <= r_dy * r_rx;
            r_dxsy <= r_dx * r_sy;
            r_dysx <= r_dy * r_sx;
            r_rxrx <= r_rx * r_rx;
            r_ryry <= r_ry * r_ry;
            r_dxrx <= r_dx * r_rx;
            r_dyry <= r_dy * r_ry;
            r_sxrx <= r_sx * r_rx;
            r_syry <= r_sy * r_ry;
        end
    end

    // Stage 3: cross and dot products
    logic                 r_v3;
    logic signed [AW-1:0] r_rs, r_qpr, r_tn, r_rr, r_d0, r_sr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_rs  <= AW'(r_rxsy) - AW'(r_rysx);
            r_qpr <= AW'(r_dxry) - AW'(r_dyrx);
            r_tn  <= AW'(r_dxsy) - AW'(r_dysx);
            r_rr  <= AW'(r_rxrx) + AW'(r_ryry);
            r_d0  <= AW'(r_dxrx) + AW'(r_dyry);
            r_sr  <= AW'(r_sxrx) + AW'(r_syry);
        end
    end

    // Stage 4: zero tests against the tolerance, sign-normalise the fractions
    logic                 r_v4, r_zr, r_zq;
    logic signed [AW-1:0] r_den, r_tn4, r_un4, r_rr4, r_d04, r_d14;
    logic                 n_zr, n_zq;
    logic signed [AW-1:0] n_den, n_tn, n_un, n_d1;
    logic [AW-1:0]        mag_rs, mag_qpr, tol_ext;

    always_comb begin
        tol_ext = {{(AW-TOL_WIDTH){1'b0}}, i_tol};
        mag_rs  = r_rs[AW-1]  ? -r_rs  : r_rs;
        mag_qpr = r_qpr[AW-1] ? -r_qpr : r_qpr;
        n_zr    = (mag_rs == '0)  || (mag_rs < tol_ext);
        n_zq    = (mag_qpr == '0) || (mag_qpr < tol_ext);
        n_den   = r_rs[AW-1] ? -r_rs  : r_rs;
        n_tn    = r_rs[AW-1] ? -r_tn  : r_tn;
        n_un    = r_rs[AW-1] ? -r_qpr : r_qpr;
        n_d1    = r_d0 + r_sr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= r_v3;
        end
        if (i_en) begin
            r_zr  <= n_zr;
            r_zq  <= n_zq;
            r_den <= n_den;
            r_tn4 <= n_tn;
            r_un4 <= n_un;
            r_rr4 <= r_rr;
            r_d04 <= r_d0;
            r_d14 <= n_d1;
        end
    end

    // Stage 5: range checks and classification into the output register
    logic    r_v5;
    t_result r_res, n_res;
    logic    overlap, in_range;

    always_comb begin
        // min(d0,d1) <= rr and max(d0,d1) >= 0, with a non-degenerate r
        overlap = (r_rr4 != '0)
               && ((r_d04 <= r_rr4) || (r_d14 <= r_rr4))
               && (!r_d04[AW-1] || !r_d14[AW-1]);
        in_range = !r_tn4[AW-1] && (r_tn4 <= r_den)
                && !r_un4[AW-1] && (r_un4 <= r_den);
        priority if (r_zr && r_zq) begin
            n_res.intersects = overlap;
            n_res.relation   = overlap ? REL_OVERLAP : REL_DISJOINT;
        end else if (r_zr) begin
            n_res.intersects = 1'b0;
            n_res.relation   = REL_PARALLEL;
        end else begin
            n_res.intersects = in_range;
            n_res.relation   = in_range ? REL_CROSS : REL_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= r_v4;
        end
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_v5;
    assign o_result = r_res;

endmodule

/* rtl/segment_intersection_test.sv */
// Path: from input acceptance to a valid result in the output register,
// through five register stages.
// Throughput: one segment pair per cycle; the five-stage pipeline holds as a whole
// while a finished result waits at the output, and takes the next item the same cycle
// the result leaves.
// Reset: synchronous, active low; clears all stage valid bits and loads tolerance 7.
module segment_intersection_test import sit_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_p_x,
    input  logic signed [COORD_WIDTH-1:0] i_p_y,
    input  logic signed [COORD_WIDTH-1:0] i_r_x,
    input  logic signed [COORD_WIDTH-1:0] i_r_y,
    input  logic signed [COORD_WIDTH-1:0] i_q_x,
    input  logic signed [COORD_WIDTH-1:0] i_q_y,
    input  logic signed [COORD_WIDTH-1:0] i_s_x,
    input  logic signed [COORD_WIDTH-1:0] i_s_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_intersects,
    output logic [2:0]                    o_relation,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [TOL_WIDTH-1:0]          i_cfg_data
);

    logic                 pipe_en, pipe_valid;
    t_result              pipe_res;
    logic [TOL_WIDTH-1:0] r_tol;

    // Advance the whole pipeline unless a result is held at the output
    assign pipe_en = !pipe_valid || i_ready;
    assign o_ready = pipe_en;

    // Tolerance register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tol <= i_cfg_data;
        end
    end

    sit_pipe #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_valid  (i_valid),
        .i_p_x    (i_p_x),
        .i_p_y    (i_p_y),
        .i_r_x    (i_r_x),
        .i_r_y    (i_r_y),
        .i_q_x    (i_q_x),
        .i_q_y    (i_q_y),
        .i_s_x    (i_s_x),
        .i_s_y    (i_s_y),
        .i_tol    (r_tol),
        .o_valid  (pipe_valid),
        .o_result (pipe_res)
    );

    assign o_valid      = pipe_valid;
    assign o_intersects = pipe_res.intersects;
    assign o_relation   = pipe_res.relation;

    // A hit is reported only for a crossing or a collinear overlap
    a_hit_matches_relation: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_intersects == ((o_relation == REL_CROSS) ||
                                      (o_relation == REL_OVERLAP)))
    ) else $error("intersect flag disagrees with relation code");

    // An accepted item reaches the output once it has advanced unstalled through every stage
    a_latency: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 pipe_en ##1 pipe_en ##1 pipe_en ##1 pipe_en
        |=> o_valid
    ) else $error("accepted item lost in pipeline");

    // A held result keeps its classification while stalled
    a_hold_stalled: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_intersects) && $stable(o_relation))
    ) else $error("pipeline advanced while output stalled");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the segment intersection test block.
`timescale 1ns / 100ps

module testbench import sit_pkg::*; ();

    localparam int CW = COORD_WIDTH_DEF;

    typedef struct {
        logic signed [CW-1:0] p_x, p_y, r_x, r_y;
        logic signed [CW-1:0] q_x, q_y, s_x, s_y;
    } t_seg_pair;

    // Expected-result store and classifier for segment pairs
    class pair_scoreboard;
        logic [TOL_WIDTH-1:0] tolerance;
        t_result              pending_results[$];
        int                   mismatches;
        int                   checked;
        int                   rel_seen[5];

        function new();
            tolerance  = TOL_RESET;
            mismatches = 0;
            checked    = 0;
            foreach (rel_seen[i]) rel_seen[i] = 0;
        endfunction

        // A cross product counts as zero below the tolerance, or when exactly zero
        function bit near_zero(longint v);
            longint mag;
            mag = (v < 0) ? -v : v;
            return (mag == 0) || (mag < longint'(tolerance));
        endfunction

        function t_result classify_pair(t_seg_pair sp);
            longint  px, py, rx, ry, qx, qy, sx, sy, dx, dy;
            longint  rs, qpr, rr, d0, d1, lo, hi, tn, un, den;
            t_result res;
            px = sp.p_x; py = sp.p_y; rx = sp.r_x; ry = sp.r_y;
            qx = sp.q_x; qy = sp.q_y; sx = sp.s_x; sy = sp.s_y;
            dx  = qx - px;
            dy  = qy - py;
            rs  = rx * sy - ry * sx;
            qpr = dx * ry - dy * rx;
            if (near_zero(rs) && near_zero(qpr)) begin
                // collinear: project q and q+s onto r and compare with |r|^2
                rr = rx * rx + ry * ry;
                d0 = dx * rx + dy * ry;
                d1 = d0 + sx * rx + sy * ry;
                lo = (d0 <= d1) ? d0 : d1;
                hi = (d0 <= d1) ? d1 : d0;
                if (rr != 0 && lo <= rr && hi >= 0) begin
                    res.intersects = 1'b1;
                    res.relation   = REL_OVERLAP;
                end else begin
                    res.intersects = 1'b0;
                    res.relation   = REL_DISJOINT;
                end
            end else if (near_zero(rs)) begin
                res.intersects = 1'b0;
                res.relation   = REL_PARALLEL;
            end else begin
                // general case: compare t and u numerators against the denominator
                tn  = dx * sy - dy * sx;
                un  = qpr;
                den = rs;
                if (den < 0) begin
                    den = -den;
                    tn  = -tn;
                    un  = -un;
                end
                if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
                    res.intersects = 1'b1;
                    res.relation   = REL_CROSS;
                end else begin
                    res.intersects = 1'b0;
                    res.relation   = REL_MISS;
                end
            end
            return res;
        endfunction

        function void note_pair(t_seg_pair sp);
            pending_results.push_back(classify_pair(sp));
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic hit, logic [2:0] rel);
            t_result want;
            checked++;
            if (rel < 5) rel_seen[rel]++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d with nothing expected", hit, rel));
            end else begin
                want = pending_results.pop_front();
                if (hit !== want.intersects)
                    report_mismatch($sformatf("intersects %0b, expected %0b (result %0d)",
                                              hit, want.intersects, checked));
                if (rel !== want.relation)
                    report_mismatch($sformatf("relation %0d, expected %0d (result %0d)",
                                              rel, want.relation, checked));
            end
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [CW-1:0] i_p_x, i_p_y, i_r_x, i_r_y;
    logic signed [CW-1:0] i_q_x, i_q_y, i_s_x, i_s_y;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_intersects;
    logic [2:0]           o_relation;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [TOL_WIDTH-1:0] i_cfg_data;

    pair_scoreboard sb;
    int             cycle_count = 0;
    int             pairs_sent;
    int             tol_settings;
    bit             steady_send;

    segment_intersection_test #(
        .COORD_WIDTH(CW)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_p_x        (i_p_x),
        .i_p_y        (i_p_y),
        .i_r_x        (i_r_x),
        .i_r_y        (i_r_y),
        .i_q_x        (i_q_x),
        .i_q_y        (i_q_y),
        .i_s_x        (i_s_x),
        .i_s_y        (i_s_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_intersects (o_intersects),
        .o_relation   (o_relation),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop for a hung run
    initial begin
        #3_000_000;
        $display("Run timed out with %0d results outstanding", sb.pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver stall: random stalls, with i_ready held high between cycles 250 and 450
    always @(negedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= 250 && cycle_count < 450)
            i_ready = 1'b1;
        else
            i_ready = ($urandom_range(99) >= 14);
    end

    // Check each result item as it leaves
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_intersects, o_relation);
    end

    function automatic int span(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic t_seg_pair make_pair(int px, int py, int rx, int ry,
                                            int qx, int qy, int sx, int sy);
        t_seg_pair sp;
        sp.p_x = px[CW-1:0]; sp.p_y = py[CW-1:0];
        sp.r_x = rx[CW-1:0]; sp.r_y = ry[CW-1:0];
        sp.q_x = qx[CW-1:0]; sp.q_y = qy[CW-1:0];
        sp.s_x = sx[CW-1:0]; sp.s_y = sy[CW-1:0];
        return sp;
    endfunction

    // Mostly constructed geometry, with a share of raw noise
    function automatic t_seg_pair random_pair();
        int kind, px, py, rx, ry, qx, qy, sx, sy, k, j;
        kind = $urandom_range(99);
        px = span(8192); py = span(8192);
        rx = span(1024); ry = span(1024);
        qx = px + span(1024); qy = py + span(1024);
        sx = span(1024); sy = span(1024);
        if (kind < 20) begin
            px = $urandom(); py = $urandom(); rx = $urandom(); ry = $urandom();
            qx = $urandom(); qy = $urandom(); sx = $urandom(); sy = $urandom();
        end else if (kind < 45) begin
            // small free geometry: crossings and misses
        end else if (kind < 65) begin
            // s along r, q on the line of r or just off it
            k  = $urandom_range(3);
            k  = (k < 2) ? k - 2 : k - 1;
            j  = $urandom_range(4) - 2;
            rx = span(256); ry = span(256);
            sx = k * rx;    sy = k * ry;
            qx = px + j * rx + ((kind < 55) ? 0 : span(4));
            qy = py + j * ry + ((kind < 55) ? 0 : span(4));
        end else if (kind < 75) begin
            // degenerate directions
            if ($urandom_range(1)) begin
                rx = 0; ry = 0;
            end else begin
                sx = 0; sy = 0;
            end
            if ($urandom_range(1)) begin
                qx = px + span(2); qy = py + span(2);
            end
        end else if (kind < 90) begin
            // nearly parallel: cross product lands around the tolerance
            rx = span(64); ry = span(64);
            sx = rx + span(2); sy = ry + span(2);
            qx = px + span(3); qy = py + span(3);
        end else begin
            // endpoints touching
            if ($urandom_range(1)) begin
                qx = px + rx; qy = py + ry;
            end else begin
                qx = px;      qy = py;
            end
            if ($urandom_range(1)) begin
                sx = -rx; sy = -ry;
            end
        end
        return make_pair(px, py, rx, ry, qx, qy, sx, sy);
    endfunction

    // Present one item and hold it until accepted
    task automatic send_pair(t_seg_pair sp);
        @(negedge i_clk);
        i_p_x = sp.p_x; i_p_y = sp.p_y; i_r_x = sp.r_x; i_r_y = sp.r_y;
        i_q_x = sp.q_x; i_q_y = sp.q_y; i_s_x = sp.s_x; i_s_y = sp.s_y;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_pair(sp);
        pairs_sent++;
    endtask

    // Drop valid for a random gap, unless in the steady stretch
    task automatic maybe_idle();
        int gap;
        if (!steady_send && $urandom_range(99) < 14) begin
            gap = $urandom_range(1, 3);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Wait for all outstanding results, then settle the pipeline
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write the tolerance register while the block is idle
    task automatic write_tolerance(logic [TOL_WIDTH-1:0] tol);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = tol;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.tolerance = tol;
        tol_settings++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) begin
            steady_send = (n >= 40 && n < 90);
            maybe_idle();
            send_pair(random_pair());
            // hold off once until the pipeline is empty
            if (n == count / 2 && tol_settings == 2) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                while (sb.pending_results.size() != 0) @(posedge i_clk);
            end
        end
        steady_send = 1'b0;
    endtask

    task automatic run_directed();
        t_seg_pair dir_pairs[$];
        dir_pairs.push_back(make_pair(0, 0, 256, 256, 0, 256, 256, -256));     // crossing
        dir_pairs.push_back(make_pair(0, 0, 256, 256, 1024, 256, 256, -256));  // segments miss
        dir_pairs.push_back(make_pair(0, 0, 256, 0, 0, 256, 256, 0));          // parallel
        dir_pairs.push_back(make_pair(0, 0, 512, 0, 256, 0, 512, 0));          // overlap
        dir_pairs.push_back(make_pair(0, 0, 256, 0, 768, 0, 256, 0));          // disjoint
        dir_pairs.push_back(make_pair(0, 0, 256, 0, 256, 0, 256, 0));          // touch at far end
        dir_pairs.push_back(make_pair(0, 0, 256, 0, -256, 0, 256, 0));         // touch at start
        dir_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 256, 256));            // zero-length r
        dir_pairs.push_back(make_pair(5, 5, 0, 0, 5, 5, 0, 0));                // both zero-length
        dir_pairs.push_back(make_pair(0, 0, 256, 0, 128, 0, 0, 0));            // point on r
        dir_pairs.push_back(make_pair(0, 0, 256, 0, 256, -128, 0, 256));       // t at one
        dir_pairs.push_back(make_pair(0, 0, 256, 0, 0, 0, 0, 256));            // t and u at zero
        dir_pairs.push_back(make_pair(0, 0, 1, 0, 0, 0, 1, 3));                // rs under tolerance
        dir_pairs.push_back(make_pair(0, 0, 1, 0, 0, 0, 1, 7));                // rs at tolerance
        dir_pairs.push_back(make_pair(0, 0, 1, 0, 0, 5, 1, 0));                // offset under tolerance
        dir_pairs.push_back(make_pair(0, 256, 256, -256, 0, 0, 256, 256));     // positive rs cross
        dir_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767));
        dir_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768));
        dir_pairs.push_back(make_pair(-32768, 32767, 32767, -32768,
                                      32767, -32768, -32768, 32767));
        dir_pairs.push_back(make_pair(32767, -32768, -32768, -32768,
                                      -32768, 32767, 32767, 32767));
        dir_pairs.push_back(make_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
        foreach (dir_pairs[i]) send_pair(dir_pairs[i]);
    endtask

    // Main sequence
    initial begin
        sb           = new();
        pairs_sent   = 0;
        tol_settings = 0;
        steady_send  = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        {i_p_x, i_p_y, i_r_x, i_r_y} = '0;
        {i_q_x, i_q_y, i_s_x, i_s_y} = '0;

        // Reset
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        write_tolerance(16'd0);
        run_directed();
        run_random(150);
        write_tolerance(16'hFFFF);
        run_random(130);
        write_tolerance(16'($urandom_range(1, 2000)));
        run_random(150);
        write_tolerance(16'd1);
        run_random(130);
        write_tolerance(16'($urandom_range(0, 65535)));
        run_random(50);
        write_tolerance(TOL_RESET);
        run_random(100);
        drain();

        $display("Sent %0d segment pairs over %0d tolerance settings, %0d results checked",
                 pairs_sent, tol_settings, sb.checked);
        $display("Relations seen: cross %0d, miss %0d, parallel %0d, overlap %0d, disjoint %0d",
                 sb.rel_seen[REL_CROSS], sb.rel_seen[REL_MISS], sb.rel_seen[REL_PARALLEL],
                 sb.rel_seen[REL_OVERLAP], sb.rel_seen[REL_DISJOINT]);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
